>>> rtl/core/cfq_pkg.sv
// Shared types and codes for the circular FIFO queue.
`timescale 1ns / 1ps
package cfq_pkg;

  // Requested operation carried by an input transaction
  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_DUMP = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  localparam int unsigned WORD_W = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the incoming transaction
    logic rd_head;   // read address follows the head index
    logic load_out;  // load the output register
    logic commit;    // apply push or pop state update
    logic dump_adv;  // step the dump pointer and read ahead
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t act;
    logic    empty;
    logic    at_tail;
    logic    out_free;
  } sts_t;

endpackage

>>> rtl/core/cfq_ram.sv
// Generic single write port RAM with registered read data.
`timescale 1ns / 1ps
module cfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> rtl/core/cfq_ctrl.sv
// Controller state machine for the circular FIFO queue.
`timescale 1ns / 1ps
module cfq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_action,
  output logic             in_stall,
  input  cfq_pkg::sts_t    sts,
  output cfq_pkg::cmd_t    cmd
);
  import cfq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.rd_head = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (action_t'(in_action) != ACT_NONE) begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.act == ACT_DUMP && !sts.empty && !sts.at_tail) begin
            cmd.dump_adv = 1'b1;
          end else begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Results are only loaded when the output register can take them
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output loaded while occupied and stalled");

  // A finished transaction always returns the controller to idle
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE)
    else $error("controller did not return to idle after commit");

endmodule

>>> rtl/core/cfq_dp.sv
// Datapath: indices, storage, transaction latch and output register.
`timescale 1ns / 1ps
module cfq_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_action,
  input  logic signed [31:0]           in_value,
  input  cfq_pkg::cmd_t                cmd,
  output cfq_pkg::sts_t                sts,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic signed [31:0]           out_data,
  output logic                         out_last
);
  import cfq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [AW-1:0]     head_r;
  logic [AW-1:0]     tail_r;
  logic [AW-1:0]     pos_r;
  logic              empty_r;
  action_t           act_r;
  logic [WORD_W-1:0] value_r;
  logic              out_valid_r;
  status_t           status_r;
  logic [WORD_W-1:0] data_r;
  logic              last_r;

  logic              full;
  logic              at_tail;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     tail_adv;
  logic [AW-1:0]     head_adv;
  logic [AW-1:0]     pos_adv;
  status_t           status_nxt;
  logic [WORD_W-1:0] data_nxt;
  logic              last_nxt;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  assign tail_adv = advance(tail_r);
  assign head_adv = advance(head_r);
  assign pos_adv  = advance(pos_r);
  assign full     = !empty_r && (tail_adv == head_r);
  assign at_tail  = (pos_r == tail_r);

  // Storage access
  assign wr_en   = cmd.commit && (act_r == ACT_PUSH) && !full;
  assign wr_addr = empty_r ? '0 : tail_adv;
  assign rd_addr = cmd.dump_adv ? pos_adv : (cmd.rd_head ? head_r : pos_r);

  cfq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (value_r),
    .raddr   (rd_addr),
    .rdata_r (rd_data)
  );

  // Transaction latch and dump pointer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r   <= action_t'(in_action);
      value_r <= in_value;
      pos_r   <= head_r;
    end else if (cmd.dump_adv) begin
      pos_r   <= pos_adv;
    end
  end

  // Queue indices and empty flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.commit) begin
      if (act_r == ACT_PUSH && !full) begin
        if (empty_r) begin
          head_r  <= '0;
          tail_r  <= '0;
          empty_r <= 1'b0;
        end else begin
          tail_r  <= tail_adv;
        end
      end else if (act_r == ACT_POP && !empty_r) begin
        if (head_r == tail_r) begin
          head_r  <= '0;
          tail_r  <= '0;
          empty_r <= 1'b1;
        end else begin
          head_r  <= head_adv;
        end
      end
    end
  end

  // Result fields for the current transaction
  always_comb begin
    status_nxt = ST_OK;
    data_nxt   = '0;
    last_nxt   = 1'b1;
    unique case (act_r)
      ACT_PUSH: begin
        status_nxt = full ? ST_OVERFLOW : ST_OK;
      end
      ACT_POP: begin
        if (empty_r) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          data_nxt = rd_data;
        end
      end
      ACT_DUMP: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          data_nxt = rd_data;
          last_nxt = at_tail;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_last   = last_r;

  assign sts.act      = act_r;
  assign sts.empty    = empty_r;
  assign sts.at_tail  = at_tail;
  assign sts.out_free = !out_valid_r || !out_stall;

  // An empty queue always has both indices parked at zero
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("empty queue with non-zero indices");

  // A load always presents a result on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> rtl/core/circular_fifo_queue.sv
// Top level of the circular FIFO queue of signed 32-bit words.
//
// Input channel (in_valid, in_stall, in_action, in_value): one transaction
// is one action - push in_value, pop the oldest word, or dump all words.
// Action code 3 is swallowed with no result.
// Result channel (out_valid, out_stall, out_status, out_data, out_last):
// push and pop give one result; a dump gives one result per stored word,
// oldest first, with out_last on the newest, or one empty result.
// out_valid rises once the execute state loads the result into the output
// register. Each transaction is accepted in the idle state and then executed,
// push and pop with the storage read data from the registered read port; a
// dump streams one word per cycle from the RAM read port while the output register is free.
// in_stall is high while a transaction executes; the next transaction is
// accepted even while the last result still waits in the output register.
// When out_stall is high the result and its payload are held, and the
// execution of further results waits for the register to drain.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
`timescale 1ns / 1ps
module circular_fifo_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic               out_last
);
  import cfq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing
  cfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and result path
  cfq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_action),
    .in_value   (in_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_data   (out_data),
    .out_last   (out_last)
  );

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the circular FIFO queue: random and directed push, pop and dump.
`timescale 1ns / 1ps
module tb;
  import cfq_pkg::*;

  localparam int unsigned DEPTH = 8;
  localparam int unsigned STALL_LIMIT = 4000;   // cycles with no transaction on either side
  localparam int unsigned ITEMS_PER_PHASE = 33;

  // Predicts the result stream of the queue and holds what is still owed
  class fifo_scoreboard;
    typedef struct packed {
      status_t     status;
      logic [31:0] data;
      logic        last;
    } fifo_result_t;

    logic [31:0]  slot_q [DEPTH];
    int unsigned  head_idx;
    int unsigned  tail_idx;
    bit           is_empty;
    fifo_result_t owed_q [$];

    function new();
      head_idx = 0;
      tail_idx = 0;
      is_empty = 1'b1;
    endfunction

    function int unsigned next_idx(int unsigned i);
      return (i + 1 == DEPTH) ? 0 : i + 1;
    endfunction

    function void queue_result(status_t st, logic [31:0] word, logic fin);
      fifo_result_t r;
      r.status = st;
      r.data   = word;
      r.last   = fin;
      owed_q.push_back(r);
    endfunction

    // Update the queue state for an accepted transaction and note its results
    function void note_input(action_t act, logic [31:0] val);
      int unsigned pos;
      bit          fin;
      case (act)
        ACT_PUSH: begin
          if (!is_empty && next_idx(tail_idx) == head_idx) begin
            queue_result(ST_OVERFLOW, '0, 1'b1);
          end else begin
            if (is_empty) begin
              head_idx = 0;
              tail_idx = 0;
              is_empty = 1'b0;
            end else begin
              tail_idx = next_idx(tail_idx);
            end
            slot_q[tail_idx] = val;
            queue_result(ST_OK, '0, 1'b1);
          end
        end
        ACT_POP: begin
          if (is_empty) begin
            queue_result(ST_UNDERFLOW, '0, 1'b1);
          end else begin
            queue_result(ST_OK, slot_q[head_idx], 1'b1);
            if (head_idx == tail_idx) begin
              is_empty = 1'b1;
              head_idx = 0;
              tail_idx = 0;
            end else begin
              head_idx = next_idx(head_idx);
            end
          end
        end
        ACT_DUMP: begin
          if (is_empty) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            pos = head_idx;
            for (int unsigned k = 0; k < DEPTH; k++) begin
              fin = (pos == tail_idx) || (k == DEPTH - 1);
              queue_result(ST_OK, slot_q[pos], fin);
              if (fin) break;
              pos = next_idx(pos);
            end
          end
        end
        default: ;  // unused code: no result, no state change
      endcase
    endfunction

    // Empty string when the result matches the oldest owed one
    function string check_result(logic [1:0] st, logic [31:0] word, logic fin);
      fifo_result_t want;
      if (owed_q.size() == 0)
        return $sformatf("result with none owed: status=%0d data=%h last=%b", st, word, fin);
      want = owed_q.pop_front();
      if (st !== want.status || word !== want.data || fin !== want.last)
        return $sformatf("got status=%0d data=%h last=%b, want status=%0d data=%h last=%b",
                         st, word, fin, want.status, want.data, want.last);
      return "";
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_NONE;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_data;
  logic               out_last;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  string       check_msg;

  fifo_scoreboard sb;

  circular_fifo_queue #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_status(out_status),
    .out_data  (out_data),
    .out_last  (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] ERROR %s", $time, what);
  endtask

  // Present one transaction from a falling edge and hold it until accepted
  task automatic send_op(input action_t act, input logic [31:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(act, val);
    if (act != ACT_NONE) items_sent++;
    @(negedge clk);
  endtask

  // Mostly full random words, with a share of corner values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_msg = sb.check_result(out_status, out_data, out_last);
      if (check_msg != "") report_mismatch(check_msg);
    end
  end

  // Watchdog: give up after a long stretch with no transaction anywhere
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("circular_fifo_queue: mismatch");
    $finish;
  end

  initial begin
    int          roll;
    bit          push_heavy;
    action_t     act;
    int unsigned phase_base;

    sb = new();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_gap_pct = 36;
    stall_pct    = 67;

    // Directed: empty cases, ignored code, corner words, fill, overflow, wrap
    send_op(ACT_POP,  32'h1111_1111);
    send_op(ACT_DUMP, 32'h2222_2222);
    send_op(ACT_NONE, 32'hDEAD_BEEF);
    send_op(ACT_PUSH, 32'h7FFF_FFFF);
    send_op(ACT_POP,  32'h0);          // pops the only word
    send_op(ACT_PUSH, 32'h8000_0000);  // push into empty queue
    send_op(ACT_PUSH, 32'hFFFF_FFFF);
    send_op(ACT_PUSH, 32'h0000_0000);
    send_op(ACT_PUSH, 32'd5);
    send_op(ACT_PUSH, 32'hAAAA_AAAA);
    send_op(ACT_PUSH, 32'h5555_5555);
    send_op(ACT_PUSH, 32'hFFFF_0000);
    send_op(ACT_PUSH, 32'h0000_FFFF);  // now full
    send_op(ACT_PUSH, 32'h0000_0001);  // overflow
    send_op(ACT_DUMP, 32'h0);          // full dump
    send_op(ACT_POP,  32'h0);
    send_op(ACT_PUSH, 32'h1234_5678);  // tail wraps
    send_op(ACT_DUMP, 32'h0);
    send_op(ACT_POP,  32'h0);
    send_op(ACT_POP,  32'h0);
    send_op(ACT_DUMP, 32'h0);

    // Random phases, bursts leaning towards filling or draining
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_gap_pct = 36; stall_pct = 67; end
        1: begin send_gap_pct = 67; stall_pct = 36; end
        default: begin send_gap_pct = 0; stall_pct = 0; end
      endcase
      phase_base = items_sent;
      push_heavy = 1'b1;
      while (items_sent - phase_base < ITEMS_PER_PHASE) begin
        if ((items_sent - phase_base) % 10 == 0) push_heavy = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 4)
          act = ACT_NONE;
        else if (roll < 19)
          act = ACT_DUMP;
        else if (roll < (push_heavy ? 75 : 40))
          act = ACT_PUSH;
        else
          act = ACT_POP;
        send_op(act, rand_word());
      end
    end
    in_valid <= 1'b0;

    // Drain what is owed, then keep waiting for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0)
      $display("circular_fifo_queue: match");
    else
      $display("circular_fifo_queue: mismatch");
    $finish;
  end

endmodule
